// File: sv/h75s_pkg.sv
// ============================================================================
// h75s_pkg
// Shared types, constants and helpers for the double-buffered panel scanner.
// ============================================================================
package h75s_pkg;

    // Input operation codes carried on the slave tuser field.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SWAP  = 2'd2
    } t_op;

    localparam int OP_W       = 2;
    localparam int COORD_W    = 6;
    localparam int COLOR_W    = 24;
    localparam int RGB_W      = 3;
    localparam int ROW_PIN_W  = 5;
    localparam int IN_TDATA_W = 40;
    localparam int PIN_W      = 14;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_DEPTH  = 3;
    localparam int OUT_CNT_W  = 2;

    localparam logic [COLOR_W-1:0] RED_MASK   = 24'h0000FF;
    localparam logic [COLOR_W-1:0] GREEN_MASK = 24'h00FF00;
    localparam logic [COLOR_W-1:0] BLUE_MASK  = 24'hFF0000;

    // One tick after its control pins are settled, waiting for memory data.
    typedef struct packed {
        logic                 valid;
        logic                 load;
        logic                 clk;
        logic                 stb;
        logic                 oe;
        logic [ROW_PIN_W-1:0] row;
    } t_tick;

    // Full pin snapshot, packed in output tdata order (lowest bit last).
    typedef struct packed {
        logic [ROW_PIN_W-1:0] row;
        logic                 oe;
        logic                 stb;
        logic                 clk;
        logic [2*RGB_W-1:0]   data;
    } t_pins;

    // A channel is lit when its byte is nonzero.
    function automatic logic [RGB_W-1:0] color_bits(input logic [COLOR_W-1:0] c);
        color_bits = {|(c & BLUE_MASK), |(c & GREEN_MASK), |(c & RED_MASK)};
    endfunction

endpackage

// File: sv/h75s_ram.sv
// ============================================================================
// h75s_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module h75s_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/h75s_scan_ctrl.sv
// ============================================================================
// h75s_scan_ctrl
// Scan sequencer: phase and row counters, bank select, swap handling,
// control pin levels and frame store address generation.
// ============================================================================
module h75s_scan_ctrl #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_tick,
    input  logic                      i_write,
    input  logic                      i_swap,
    input  logic [h75s_pkg::COORD_W-1:0] i_x,
    input  logic [h75s_pkg::COORD_W-1:0] i_y,
    output logic [$clog2(2*(PANEL_HEIGHT/2)*PANEL_WIDTH)-1:0] o_rd_addr,
    output logic [$clog2(2*(PANEL_HEIGHT/2)*PANEL_WIDTH)-1:0] o_wr_addr,
    output logic                      o_wr_top,
    output logic                      o_wr_bot,
    output h75s_pkg::t_tick           o_tick
);
    import h75s_pkg::*;

    localparam int SCAN_ROWS  = PANEL_HEIGHT / 2;
    localparam int BANK_WORDS = SCAN_ROWS * PANEL_WIDTH;
    localparam int AW         = $clog2(2 * BANK_WORDS);
    localparam int PHASES     = 2 * PANEL_WIDTH + 4;
    localparam int PW         = $clog2(PHASES);
    localparam int CW         = $clog2(PANEL_WIDTH);
    localparam int RW         = $clog2(SCAN_ROWS);
    localparam int LINE_END   = 2 * PANEL_WIDTH;

    logic [PW-1:0]        r_phase, n_phase;
    logic [RW-1:0]        r_row, n_row;
    logic                 r_bank, n_bank;
    logic                 r_swap, n_swap;
    logic                 r_clk, n_clk;
    logic                 r_stb, n_stb;
    logic                 r_oe, n_oe;
    logic [ROW_PIN_W-1:0] r_row_pin, n_row_pin;
    logic                 n_load;
    t_tick                r_tick;
    logic                 eff_bank;
    logic [CW-1:0]        col;
    logic                 x_ok, y_top, y_bot;
    logic [RW-1:0]        wr_row;

    // A pending swap takes effect at the first phase of a row.
    assign eff_bank = (r_phase == '0 && r_swap) ? ~r_bank : r_bank;
    assign col      = r_phase[CW:1];

    // Both halves share the address: top memory holds rows 0..S-1,
    // bottom memory holds rows S..2S-1.
    assign o_rd_addr = AW'(eff_bank) * AW'(BANK_WORDS) + AW'(r_row) * AW'(PANEL_WIDTH)
                       + AW'(col);

    // Write address into the back bank.
    assign x_ok   = {2'b00, i_x} < 8'(PANEL_WIDTH);
    assign y_top  = {1'b0, i_y} < 7'(SCAN_ROWS);
    assign y_bot  = !y_top && ({1'b0, i_y} < 7'(2 * SCAN_ROWS));
    assign wr_row = y_top ? RW'(i_y) : RW'({1'b0, i_y} - 7'(SCAN_ROWS));

    assign o_wr_addr = AW'(~r_bank) * AW'(BANK_WORDS) + AW'(wr_row) * AW'(PANEL_WIDTH)
                       + AW'(i_x);
    assign o_wr_top  = i_write && x_ok && y_top;
    assign o_wr_bot  = i_write && x_ok && y_bot;

    // Next state of the sequencer and the control pins.
    always_comb begin
        n_phase   = r_phase;
        n_row     = r_row;
        n_bank    = r_bank;
        n_swap    = r_swap;
        n_clk     = r_clk;
        n_stb     = r_stb;
        n_oe      = r_oe;
        n_row_pin = r_row_pin;
        n_load    = 1'b0;
        if (i_swap) begin
            n_swap = 1'b1;
        end
        if (i_tick) begin
            n_bank = eff_bank;
            if (r_phase == '0) begin
                n_swap = 1'b0;
            end
            if (r_phase < PW'(LINE_END)) begin
                n_clk  = ~r_phase[0];
                n_load = ~r_phase[0];
            end else if (r_phase == PW'(LINE_END)) begin
                n_oe      = 1'b1;
                n_row_pin = ROW_PIN_W'(r_row);
            end else if (r_phase == PW'(LINE_END + 1)) begin
                n_stb = 1'b1;
            end else if (r_phase == PW'(LINE_END + 2)) begin
                n_stb = 1'b0;
            end else begin
                n_oe = 1'b0;
            end
            if (r_phase == PW'(PHASES - 1)) begin
                n_phase = '0;
                n_row   = (r_row == RW'(SCAN_ROWS - 1)) ? '0 : r_row + 1'b1;
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
    end

    // Sequencer registers and the tick stage toward the memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_row     <= '0;
            r_bank    <= 1'b0;
            r_swap    <= 1'b0;
            r_clk     <= 1'b0;
            r_stb     <= 1'b0;
            r_oe      <= 1'b0;
            r_row_pin <= '0;
            r_tick    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_row        <= n_row;
            r_bank       <= n_bank;
            r_swap       <= n_swap;
            r_clk        <= n_clk;
            r_stb        <= n_stb;
            r_oe         <= n_oe;
            r_row_pin    <= n_row_pin;
            r_tick.valid <= i_tick;
            r_tick.load  <= n_load;
            r_tick.clk   <= n_clk;
            r_tick.stb   <= n_stb;
            r_tick.oe    <= n_oe;
            r_tick.row   <= n_row_pin;
        end
    end

    assign o_tick = r_tick;

endmodule

// File: sv/h75s_out_fifo.sv
// ============================================================================
// h75s_out_fifo
// Small output queue that decouples the scan pipeline from the receiver.
// ============================================================================
module h75s_out_fifo #(
    parameter int WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    output logic [h75s_pkg::OUT_CNT_W-1:0] o_count,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [WIDTH-1:0]               o_data
);
    import h75s_pkg::*;

    logic [WIDTH-1:0]     r_mem [OUT_DEPTH];
    logic [OUT_CNT_W-1:0] r_wr, r_rd, r_count;
    logic                 pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == OUT_CNT_W'(OUT_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == OUT_CNT_W'(OUT_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop);
        end
    end

endmodule

// File: sv/hub75_double_buffered_scanner_core.sv
// ============================================================================
// hub75_double_buffered_scanner_core
// Double-buffered scan driver for a 1:(H/2) scan LED panel.
// ============================================================================
// Usage:
//   The slave stream takes one item per transfer. tuser carries the
//   operation: tick one scan phase, write a pixel into the back bank, or
//   request a bank swap. A swap is applied at the start of the next row.
//   Each tick yields one master transfer with every pin level of that phase;
//   writes, swaps and the unused code yield nothing.
//   A tick's result passes the frame store read, then the output queue,
//   before it is visible. Throughput is one item per cycle while
//   s_axis_tready is high: the frame store is split into top and bottom
//   half memories so both pixels of a column are read in the same cycle.
//   Reset clears all scan state and then sweeps the frame store to zero,
//   one word of each half memory per cycle, over 2*(H/2)*W words (4096 at
//   the default size); s_axis_tready stays low during that sweep.
//   When the receiver stalls, a three-entry output queue absorbs results
//   in flight, and s_axis_tready drops once the queue and the read stage
//   would fill it.
// ============================================================================
module hub75_double_buffered_scanner_core #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_coord[5:0], y_coord[11:6], pixel_color[35:12], zero pad [39:36]
    input  logic [h75s_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[1:0]
    input  logic [h75s_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red_top[0], green_top[1], blue_top[2], red_bottom[3], green_bottom[4],
    // blue_bottom[5], shift_clock[6], latch_strobe[7], output_enable[8],
    // row_address[13:9], zero pad [15:14]
    output logic [h75s_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import h75s_pkg::*;

    localparam int SCAN_ROWS  = PANEL_HEIGHT / 2;
    localparam int HALF_WORDS = 2 * SCAN_ROWS * PANEL_WIDTH;
    localparam int AW         = $clog2(HALF_WORDS);

    logic                 in_fire;
    logic                 tick, write, swap;
    logic [COORD_W-1:0]   in_x, in_y;
    logic [COLOR_W-1:0]   in_color;
    logic [AW-1:0]        rd_addr, wr_addr, mem_waddr;
    logic                 wr_top, wr_bot;
    logic [RGB_W-1:0]     mem_wdata, q_top, q_bot;
    t_tick                s1;
    logic [2*RGB_W-1:0]   r_data, cur_data;
    t_pins                pins;
    logic [OUT_CNT_W-1:0] q_count;
    logic                 r_clearing;
    logic [AW-1:0]        r_clr_addr;

    assign in_x     = s_axis_tdata[COORD_W-1:0];
    assign in_y     = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_color = s_axis_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];

    // Accept while not clearing and the output queue has room for every
    // tick in flight.
    assign s_axis_tready = !r_clearing
                           && ((3'(q_count) + 3'(s1.valid)) < 3'(OUT_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Operation decode.
    always_comb begin
        tick  = 1'b0;
        write = 1'b0;
        swap  = 1'b0;
        if (in_fire) begin
            unique case (t_op'(s_axis_tuser))
                OP_TICK:  tick  = 1'b1;
                OP_WRITE: write = 1'b1;
                OP_SWAP:  swap  = 1'b1;
                default:  ;
            endcase
        end
    end

    h75s_scan_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_scan_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_write   (write),
        .i_swap    (swap),
        .i_x       (in_x),
        .i_y       (in_y),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_wr_top  (wr_top),
        .o_wr_bot  (wr_bot),
        .o_tick    (s1)
    );

    // Clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(HALF_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Write port shared between the sweep and pixel writes.
    assign mem_waddr = r_clearing ? r_clr_addr : wr_addr;
    assign mem_wdata = r_clearing ? '0 : color_bits(in_color);

    h75s_ram #(
        .WIDTH (RGB_W),
        .DEPTH (HALF_WORDS)
    ) u_ram_top (
        .i_clk   (i_clk),
        .i_we    (r_clearing || wr_top),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (q_top)
    );

    h75s_ram #(
        .WIDTH (RGB_W),
        .DEPTH (HALF_WORDS)
    ) u_ram_bot (
        .i_clk   (i_clk),
        .i_we    (r_clearing || wr_bot),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (q_bot)
    );

    // Data pins load on clock-high phases and hold otherwise.
    assign cur_data = s1.load ? {q_bot, q_top} : r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (s1.valid) begin
            r_data <= cur_data;
        end
    end

    always_comb begin
        pins.row  = s1.row;
        pins.oe   = s1.oe;
        pins.stb  = s1.stb;
        pins.clk  = s1.clk;
        pins.data = cur_data;
    end

    h75s_out_fifo #(
        .WIDTH (OUT_TDATA_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1.valid),
        .i_data  ({{(OUT_TDATA_W - PIN_W){1'b0}}, pins}),
        .o_count (q_count),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for hub75_double_buffered_scanner_core
// Drives pixel writes, bank swaps, scan ticks and the unused code into the
// slave stream and checks every pin snapshot on the master stream against a
// cycle-free model of the double-buffered panel scanner kept in this file.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import h75s_pkg::*;

    localparam int PANEL_W     = 64;
    localparam int PANEL_H     = 64;
    localparam int SCAN_ROWS   = PANEL_H / 2;
    localparam int ROW_PHASES  = 2 * PANEL_W + 4;
    localparam int MODE_TICKS  = 220;
    localparam int SETTLE_CYC  = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX  = 10;

    // The fourth operation code is not decoded by the block.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One pin snapshot, laid out as in the master tdata.
    typedef struct packed {
        logic [ROW_PIN_W-1:0] row;
        logic                 oe;
        logic                 stb;
        logic                 clk;
        logic [RGB_W-1:0]     bottom;
        logic [RGB_W-1:0]     top;
    } pin_word_t;

    // One pending slave transfer, or a marker that holds the sender back.
    typedef struct {
        bit                 hold;
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        int unsigned        send_gap_pct;
        int unsigned        recv_stall_pct;
    } scan_item_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Stimulus backlog and the pin snapshots still to arrive.
    scan_item_t  item_backlog[$];
    pin_word_t   pins_due[$];
    bit          in_flight = 1'b0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Scanner model state.
    logic [RGB_W-1:0]     pixel_mem [2][PANEL_H][PANEL_W];
    logic                 shown_bank;
    logic                 swap_req;
    logic [ROW_PIN_W-1:0] scan_row_q;
    int unsigned          scan_phase_q;
    pin_word_t            pins_now;

    // Scan position as seen by the stimulus generator.
    int unsigned gen_phase = 0;
    int unsigned gen_row = 0;
    int unsigned mode_ticks = 0;
    int unsigned cur_send_pct = 0;
    int unsigned cur_recv_pct = 0;

    hub75_double_buffered_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Step the scanner by one pin phase and return every pin level.
    function automatic pin_word_t scan_tick_pins();
        int col;
        if (scan_phase_q == 0 && swap_req) begin
            shown_bank = ~shown_bank;
            swap_req   = 1'b0;
        end
        if (scan_phase_q < 2 * PANEL_W) begin
            col = scan_phase_q / 2;
            if (scan_phase_q % 2 == 0) begin
                pins_now.top    = pixel_mem[shown_bank][scan_row_q][col];
                pins_now.bottom = pixel_mem[shown_bank][scan_row_q + SCAN_ROWS][col];
                pins_now.clk    = 1'b1;
            end else begin
                pins_now.clk = 1'b0;
            end
        end else if (scan_phase_q == 2 * PANEL_W) begin
            pins_now.oe  = 1'b1;
            pins_now.row = scan_row_q;
        end else if (scan_phase_q == 2 * PANEL_W + 1) begin
            pins_now.stb = 1'b1;
        end else if (scan_phase_q == 2 * PANEL_W + 2) begin
            pins_now.stb = 1'b0;
        end else begin
            pins_now.oe = 1'b0;
        end
        scan_phase_q++;
        if (scan_phase_q >= ROW_PHASES) begin
            scan_phase_q = 0;
            scan_row_q   = (scan_row_q == SCAN_ROWS - 1) ? '0 : scan_row_q + 1'b1;
        end
        return pins_now;
    endfunction

    // Update the model with one accepted item.
    task automatic apply_item(input scan_item_t it);
        case (it.op)
            OP_WRITE: begin
                pixel_mem[~shown_bank][it.y][it.x] =
                    {|it.color[23:16], |it.color[15:8], |it.color[7:0]};
            end
            OP_SWAP: swap_req = 1'b1;
            OP_TICK: pins_due.push_back(scan_tick_pins());
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s expected %0h got %0h",
                     cycle_count, what, want, got);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
            note_mismatch(name, want, got);
    endtask

    // Compare one received pin snapshot with the oldest one expected.
    task automatic check_pins(input logic [OUT_TDATA_W-1:0] word);
        pin_word_t got;
        pin_word_t want;
        got = pin_word_t'(word[PIN_W-1:0]);
        if (pins_due.size() == 0) begin
            note_mismatch("unrequested snapshot", '0, word);
            return;
        end
        want = pins_due.pop_front();
        compare_field("top rgb", want.top, got.top);
        compare_field("bottom rgb", want.bottom, got.bottom);
        compare_field("shift clock", want.clk, got.clk);
        compare_field("latch strobe", want.stb, got.stb);
        compare_field("output enable", want.oe, got.oe);
        compare_field("row address", want.row, got.row);
        compare_field("pad bits", '0, word[OUT_TDATA_W-1:PIN_W]);
    endtask

    task automatic push_item(input logic [OP_W-1:0] op, input int x, input int y,
                             input logic [COLOR_W-1:0] color);
        scan_item_t it;
        it.hold           = 1'b0;
        it.op             = op;
        it.x              = COORD_W'(x);
        it.y              = COORD_W'(y);
        it.color          = color;
        it.send_gap_pct   = cur_send_pct;
        it.recv_stall_pct = cur_recv_pct;
        item_backlog.push_back(it);
        if (op == OP_TICK) begin
            mode_ticks++;
            gen_phase++;
            if (gen_phase == ROW_PHASES) begin
                gen_phase = 0;
                gen_row   = (gen_row + 1) % SCAN_ROWS;
            end
        end
    endtask

    // Marker that keeps the sender quiet until all snapshots are in.
    task automatic push_hold();
        scan_item_t it;
        it = '{default: '0};
        it.hold = 1'b1;
        item_backlog.push_back(it);
    endtask

    // Each channel byte is dark, full, a single low or high bit, or random.
    function automatic logic [COLOR_W-1:0] rand_color();
        logic [COLOR_W-1:0] c;
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(4))
                0:       c[8*i +: 8] = 8'h00;
                1:       c[8*i +: 8] = 8'hFF;
                2:       c[8*i +: 8] = 8'h01;
                3:       c[8*i +: 8] = 8'h80;
                default: c[8*i +: 8] = 8'($urandom_range(255));
            endcase
        end
        return c;
    endfunction

    // Fill the back bank for the row about to start, maybe swap, then scan a while.
    task automatic push_burst();
        int unsigned target;
        int unsigned n;
        target = (gen_phase == 0) ? gen_row : (gen_row + 1) % SCAN_ROWS;
        n = $urandom_range(6);
        repeat (n)
            push_item(OP_WRITE, $urandom_range(PANEL_W - 1),
                      target + ($urandom_range(1) ? SCAN_ROWS : 0), rand_color());
        case ($urandom_range(9))
            0:               push_item(OP_UNUSED, $urandom_range(63),
                                       $urandom_range(63), COLOR_W'($urandom()));
            1:               push_item(OP_WRITE, $urandom_range(63),
                                       $urandom_range(63), rand_color());
            default: ;
        endcase
        n = $urandom_range(9);
        if (n < 6)
            push_item(OP_SWAP, $urandom_range(63), $urandom_range(63),
                      COLOR_W'($urandom()));
        if (n == 0)
            push_item(OP_SWAP, $urandom_range(63), $urandom_range(63),
                      COLOR_W'($urandom()));
        n = ($urandom_range(4) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 40);
        repeat (n)
            push_item(OP_TICK, $urandom_range(63), $urandom_range(63),
                      COLOR_W'($urandom()));
    endtask

    task automatic push_mode(input int unsigned send_pct, input int unsigned recv_pct);
        cur_send_pct = send_pct;
        cur_recv_pct = recv_pct;
        mode_ticks   = 0;
        while (mode_ticks < MODE_TICKS)
            push_burst();
    endtask

    // Acceptance of slave transfers and checking of master transfers.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            apply_item(item_backlog.pop_front());
            in_flight = 1'b0;
        end
        if (m_axis_tvalid && m_axis_tready)
            check_pins(m_axis_tdata);
    end

    // Driver and receiver: inputs change at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_flight) begin
                if (item_backlog.size() != 0 && item_backlog[0].hold) begin
                    if (pins_due.size() == 0)
                        item_backlog.delete(0);
                    s_axis_tvalid <= 1'b0;
                end else if (item_backlog.size() != 0 &&
                             $urandom_range(99) >= item_backlog[0].send_gap_pct) begin
                    s_axis_tvalid  <= 1'b1;
                    s_axis_tuser   <= item_backlog[0].op;
                    s_axis_tdata   <= {4'b0, item_backlog[0].color,
                                       item_backlog[0].y, item_backlog[0].x};
                    recv_stall_pct <= item_backlog[0].recv_stall_pct;
                    in_flight = 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // Model reset: blank store, bank zero shown, all pins low.
        for (int b = 0; b < 2; b++)
            for (int y = 0; y < PANEL_H; y++)
                for (int x = 0; x < PANEL_W; x++)
                    pixel_mem[b][y][x] = '0;
        shown_bank   = 1'b0;
        swap_req     = 1'b0;
        scan_row_q   = '0;
        scan_phase_q = 0;
        pins_now     = '0;

        // Directed part: corner pixels, each channel alone, an overwrite,
        // the unused code, merged swaps applied before the first read.
        cur_send_pct = 8;
        cur_recv_pct = 82;
        push_item(OP_WRITE, 0, 0, 24'hFFFFFF);
        push_item(OP_WRITE, 0, 32, 24'h0000FF);
        push_item(OP_WRITE, 1, 0, 24'h00FF00);
        push_item(OP_WRITE, 1, 32, 24'hFF0000);
        push_item(OP_WRITE, 2, 0, 24'h800000);
        push_item(OP_WRITE, 2, 0, 24'h000000);
        push_item(OP_WRITE, 2, 32, 24'h010101);
        push_item(OP_WRITE, 63, 63, 24'hFFFFFF);
        push_item(OP_UNUSED, 63, 63, 24'hFFFFFF);
        push_item(OP_SWAP, 0, 0, 24'h000000);
        push_item(OP_SWAP, 63, 63, 24'hFFFFFF);
        repeat (6)
            push_item(OP_TICK, 0, 0, 24'h000000);
        push_item(OP_WRITE, 3, 0, 24'hFFFFFF);
        repeat (2)
            push_item(OP_TICK, 63, 63, 24'hFFFFFF);
        push_hold();

        // Random part in three idling modes, with a full pause between them.
        push_mode(8, 82);
        push_hold();
        push_mode(82, 8);
        push_hold();
        push_mode(0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_backlog.size() != 0 || in_flight || pins_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/h75s_pkg.sv
sv/h75s_ram.sv
sv/h75s_scan_ctrl.sv
sv/h75s_out_fifo.sv
sv/hub75_double_buffered_scanner_core.sv
tb/testbench.sv
